// ----- hw/rtl/cpp_pkg.sv -----
// types, codes and rounding helpers shared by the camera point projection pipeline
`timescale 1ns / 1ps
`default_nettype none
package cpp_pkg;

  typedef enum logic [1:0] {
    ST_VISIBLE = 2'd0,
    ST_RANGE   = 2'd1,
    ST_BEHIND  = 2'd2,
    ST_MARGIN  = 2'd3
  } cpp_status_t;

  typedef enum logic [2:0] {
    CFG_ROW_ZERO   = 3'd0,
    CFG_ROW_ONE    = 3'd1,
    CFG_ROW_TWO    = 3'd2,
    CFG_INTRINSICS = 3'd3,
    CFG_RADIAL     = 3'd4,
    CFG_TANGENTIAL = 3'd5,
    CFG_DISPLAY    = 3'd6
  } cpp_cfg_idx_t;

  localparam logic [47:0] ROW_ZERO_RST   = 48'd3221225472;
  localparam logic [47:0] ROW_ONE_RST    = 48'd49152;
  localparam logic [47:0] ROW_TWO_RST    = 48'd70368744177664;
  localparam logic [23:0] DISPLAY_RST    = 24'd3277280;

  typedef struct packed {
    logic signed [23:0] forward_m;
    logic signed [23:0] left_m;
    logic signed [23:0] up_m;
  } cpp_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
  } cpp_out_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        sgn_x;
    logic        sgn_y;
    logic [57:0] num_x;
    logic [57:0] num_y;
    logic [41:0] den;
  } cpp_div_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [21:0] nx;
    logic signed [21:0] ny;
  } cpp_div_out_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
  } cpp_dist_out_t;

  function automatic logic signed [63:0] rnd_sym(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic [63:0] mag;
    mag = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    mag = (mag + (64'd1 << (s - 1))) >> s;
    return v[63] ? $signed(64'd0 - mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cpp_rotate.sv -----
// input register, view matrix rotation, range and depth checks, divider operands
`timescale 1ns / 1ps
`default_nettype none
module cpp_rotate (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire cpp_pkg::cpp_in_t     in_item,
  input  wire logic [47:0]          row_zero,
  input  wire logic [47:0]          row_one,
  input  wire logic [47:0]          row_two,
  output logic                      out_vld,
  output cpp_pkg::cpp_div_in_t      out_item
);
  import cpp_pkg::*;

  logic [3:0] vld_r;
  cpp_in_t item_r;
  logic rng_bad_r, rng_bad1_r, rng_bad2_r;
  logic signed [39:0] prod_r [0:8];
  logic signed [41:0] vx_r, vy_r, vz_r;
  cpp_div_in_t div_r;

  logic signed [23:0] crd [0:2];
  logic [47:0] rows [0:2];
  logic signed [45:0] vz10;
  logic [41:0] mag_x, mag_y;
  logic [1:0] st_nxt;

  assign crd[0] = item_r.forward_m;
  assign crd[1] = item_r.left_m;
  assign crd[2] = item_r.up_m;
  assign rows[0] = row_zero;
  assign rows[1] = row_one;
  assign rows[2] = row_two;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r    <= in_item;
      rng_bad_r <= (in_item.forward_m < 24'sd2048) || (in_item.forward_m > 24'sd491520);
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[r*3+c] <= $signed(rows[r][47-16*c -: 16]) * crd[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rng_bad1_r <= rng_bad_r;
      vx_r <= 42'(prod_r[0]) + 42'(prod_r[1]) + 42'(prod_r[2]);
      vy_r <= 42'(prod_r[3]) + 42'(prod_r[4]) + 42'(prod_r[5]);
      vz_r <= 42'(prod_r[6]) + 42'(prod_r[7]) + 42'(prod_r[8]);
      rng_bad2_r <= rng_bad1_r;
    end
  end

  always_comb begin
    vz10  = (46'(vz_r) <<< 3) + (46'(vz_r) <<< 1);
    mag_x = vx_r[41] ? 42'(-vx_r) : 42'(vx_r);
    mag_y = vy_r[41] ? 42'(-vy_r) : 42'(vy_r);
    if (rng_bad2_r) begin
      st_nxt = ST_RANGE;
    end else if (vz10 <= 46'sd67108864) begin
      st_nxt = ST_BEHIND;
    end else begin
      st_nxt = ST_VISIBLE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r.status <= st_nxt;
      div_r.sgn_x  <= vx_r[41];
      div_r.sgn_y  <= vy_r[41];
      div_r.num_x  <= {mag_x, 16'd0} + 58'(vz_r[41:1]);
      div_r.num_y  <= {mag_y, 16'd0} + 58'(vz_r[41:1]);
      div_r.den    <= vz_r;
    end
  end

  assign out_vld  = vld_r[3];
  assign out_item = div_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cpp_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes sharing the depth
`timescale 1ns / 1ps
`default_nettype none
module cpp_divider (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire cpp_pkg::cpp_div_in_t  in_item,
  output logic                       out_vld,
  output cpp_pkg::cpp_div_out_t      out_item
);
  import cpp_pkg::*;

  localparam int QBits = 21;

  logic [QBits:0]  vld_r;
  logic [57:0]     rx_r  [0:QBits];
  logic [57:0]     ry_r  [0:QBits];
  logic [QBits-1:0] qx_r [0:QBits];
  logic [QBits-1:0] qy_r [0:QBits];
  logic [41:0]     den_r [0:QBits];
  logic [1:0]      st_r  [0:QBits];
  logic [3:0]      flg_r [0:QBits];
  logic            out_vld_r;
  cpp_div_out_t    out_r;

  logic [QBits-1:0] qsx, qsy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[QBits-1:0], in_vld};
      out_vld_r <= vld_r[QBits];
    end
  end

  // flags: sign x, sign y, saturate x, saturate y
  always_ff @(posedge clk) begin
    if (en) begin
      rx_r[0]  <= in_item.num_x;
      ry_r[0]  <= in_item.num_y;
      qx_r[0]  <= '0;
      qy_r[0]  <= '0;
      den_r[0] <= in_item.den;
      st_r[0]  <= in_item.status;
      flg_r[0] <= {in_item.sgn_x, in_item.sgn_y,
                   {6'd0, in_item.num_x} >= {1'b0, in_item.den, 21'd0},
                   {6'd0, in_item.num_y} >= {1'b0, in_item.den, 21'd0}};
    end
  end

  for (genvar k = 0; k < QBits; k++) begin : g_bit
    localparam int Sh = QBits - 1 - k;
    logic [63:0] tx, ty, dsh;
    always_comb begin
      dsh = {22'd0, den_r[k]} << Sh;
      tx  = {6'd0, rx_r[k]} - dsh;
      ty  = {6'd0, ry_r[k]} - dsh;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[k+1]  <= tx[63] ? rx_r[k] : tx[57:0];
        ry_r[k+1]  <= ty[63] ? ry_r[k] : ty[57:0];
        qx_r[k+1]  <= {qx_r[k][QBits-2:0], ~tx[63]};
        qy_r[k+1]  <= {qy_r[k][QBits-2:0], ~ty[63]};
        den_r[k+1] <= den_r[k];
        st_r[k+1]  <= st_r[k];
        flg_r[k+1] <= flg_r[k];
      end
    end
  end

  always_comb begin
    qsx = (flg_r[QBits][1] || qx_r[QBits] > 21'd1048576) ? 21'd1048576 : qx_r[QBits];
    qsy = (flg_r[QBits][0] || qy_r[QBits] > 21'd1048576) ? 21'd1048576 : qy_r[QBits];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.status <= st_r[QBits];
      out_r.nx     <= flg_r[QBits][3] ? -$signed({1'b0, qsx}) : $signed({1'b0, qsx});
      out_r.ny     <= flg_r[QBits][2] ? -$signed({1'b0, qsy}) : $signed({1'b0, qsy});
    end
  end

  assign out_vld  = out_vld_r;
  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cpp_distort.sv -----
// radial and tangential lens distortion pipeline
`timescale 1ns / 1ps
`default_nettype none
module cpp_distort (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  en,
  input  wire logic                  in_vld,
  input  wire cpp_pkg::cpp_div_out_t in_item,
  input  wire logic [47:0]           radial,
  input  wire logic [31:0]           tangential,
  output logic                       out_vld,
  output cpp_pkg::cpp_dist_out_t     out_item
);
  import cpp_pkg::*;

  logic [10:0] vld_r;
  logic [1:0]  st_r [1:10];
  logic signed [21:0] nx_r [1:9];
  logic signed [21:0] ny_r [1:9];

  logic signed [15:0] k1, k2, k3, p1, p2;

  logic signed [43:0] mxx_1_r, myy_1_r, mxy_1_r;
  logic signed [25:0] nx2_2_r, ny2_2_r, nxy_2_r;
  logic signed [26:0] r2_2_r;
  logic signed [53:0] r4p_3_r;
  logic signed [42:0] k1p_3_r;
  logic signed [27:0] sx_3_r, sy_3_r;
  logic signed [26:0] r2_3_r;
  logic signed [25:0] nxy_3_r;
  logic signed [36:0] r4_4_r;
  logic signed [31:0] k1t_4_r;
  logic signed [43:0] tx2p_4_r, ty1p_4_r;
  logic signed [41:0] tx1p_4_r, ty2p_4_r;
  logic signed [26:0] r2_4_r;
  logic signed [63:0] r6p_5_r;
  logic signed [52:0] k2p_5_r;
  logic signed [31:0] k1t_5_r, tx1_5_r, tx2_5_r, ty1_5_r, ty2_5_r;
  logic signed [45:0] r6_6_r;
  logic signed [39:0] k2t_6_r;
  logic signed [31:0] k1t_6_r, tx1_6_r, tx2_6_r, ty1_6_r, ty2_6_r;
  logic signed [61:0] k3p_7_r;
  logic signed [39:0] k2t_7_r;
  logic signed [31:0] k1t_7_r, tx1_7_r, tx2_7_r, ty1_7_r, ty2_7_r;
  logic signed [47:0] k3t_8_r;
  logic signed [39:0] k2t_8_r;
  logic signed [31:0] k1t_8_r, tx1_8_r, tx2_8_r, ty1_8_r, ty2_8_r;
  logic signed [31:0] rad_9_r, tx1_9_r, tx2_9_r, ty1_9_r, ty2_9_r;
  logic signed [53:0] nxr_10_r, nyr_10_r;
  logic signed [31:0] tx1_10_r, tx2_10_r, ty1_10_r, ty2_10_r;
  cpp_dist_out_t      out_r;

  assign k1 = $signed(radial[47:32]);
  assign k2 = $signed(radial[31:16]);
  assign k3 = $signed(radial[15:0]);
  assign p1 = $signed(tangential[31:16]);
  assign p2 = $signed(tangential[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[9:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[1] <= in_item.status;
      nx_r[1] <= in_item.nx;
      ny_r[1] <= in_item.ny;
      for (int i = 2; i <= 10; i++) begin
        st_r[i] <= st_r[i-1];
      end
      for (int i = 2; i <= 9; i++) begin
        nx_r[i] <= nx_r[i-1];
        ny_r[i] <= ny_r[i-1];
      end

      mxx_1_r <= in_item.nx * in_item.nx;
      myy_1_r <= in_item.ny * in_item.ny;
      mxy_1_r <= in_item.nx * in_item.ny;

      nx2_2_r <= 26'(rnd_sym(mxx_1_r, 16));
      ny2_2_r <= 26'(rnd_sym(myy_1_r, 16));
      nxy_2_r <= 26'(rnd_sym(mxy_1_r, 16));
      r2_2_r  <= 27'(rnd_sym(64'(mxx_1_r) + 64'(myy_1_r), 16));

      r4p_3_r <= r2_2_r * r2_2_r;
      k1p_3_r <= k1 * r2_2_r;
      sx_3_r  <= 28'(r2_2_r) + (28'(nx2_2_r) <<< 1);
      sy_3_r  <= 28'(r2_2_r) + (28'(ny2_2_r) <<< 1);
      r2_3_r  <= r2_2_r;
      nxy_3_r <= nxy_2_r;

      r4_4_r   <= 37'(rnd_sym(r4p_3_r, 16));
      k1t_4_r  <= 32'(rnd_sym(k1p_3_r, 12));
      tx2p_4_r <= p2 * sx_3_r;
      ty1p_4_r <= p1 * sy_3_r;
      tx1p_4_r <= p1 * nxy_3_r;
      ty2p_4_r <= p2 * nxy_3_r;
      r2_4_r   <= r2_3_r;

      r6p_5_r <= r4_4_r * r2_4_r;
      k2p_5_r <= k2 * r4_4_r;
      k1t_5_r <= k1t_4_r;
      tx1_5_r <= 32'(rnd_sym(tx1p_4_r, 13));
      tx2_5_r <= 32'(rnd_sym(tx2p_4_r, 14));
      ty1_5_r <= 32'(rnd_sym(ty1p_4_r, 14));
      ty2_5_r <= 32'(rnd_sym(ty2p_4_r, 13));

      r6_6_r  <= 46'(rnd_sym(r6p_5_r, 16));
      k2t_6_r <= 40'(rnd_sym(k2p_5_r, 12));
      k1t_6_r <= k1t_5_r;
      tx1_6_r <= tx1_5_r;
      tx2_6_r <= tx2_5_r;
      ty1_6_r <= ty1_5_r;
      ty2_6_r <= ty2_5_r;

      k3p_7_r <= k3 * r6_6_r;
      k2t_7_r <= k2t_6_r;
      k1t_7_r <= k1t_6_r;
      tx1_7_r <= tx1_6_r;
      tx2_7_r <= tx2_6_r;
      ty1_7_r <= ty1_6_r;
      ty2_7_r <= ty2_6_r;

      k3t_8_r <= 48'(rnd_sym(k3p_7_r, 12));
      k2t_8_r <= k2t_7_r;
      k1t_8_r <= k1t_7_r;
      tx1_8_r <= tx1_7_r;
      tx2_8_r <= tx2_7_r;
      ty1_8_r <= ty1_7_r;
      ty2_8_r <= ty2_7_r;

      rad_9_r <= sat32(64'sd65536 + 64'(k1t_8_r) + 64'(k2t_8_r) + 64'(k3t_8_r));
      tx1_9_r <= tx1_8_r;
      tx2_9_r <= tx2_8_r;
      ty1_9_r <= ty1_8_r;
      ty2_9_r <= ty2_8_r;

      nxr_10_r <= nx_r[9] * rad_9_r;
      nyr_10_r <= ny_r[9] * rad_9_r;
      tx1_10_r <= tx1_9_r;
      tx2_10_r <= tx2_9_r;
      ty1_10_r <= ty1_9_r;
      ty2_10_r <= ty2_9_r;

      out_r.status <= st_r[10];
      out_r.dx <= sat32(rnd_sym(nxr_10_r, 16) - 64'(tx1_10_r) - 64'(tx2_10_r));
      out_r.dy <= sat32(rnd_sym(nyr_10_r, 16) - 64'(ty1_10_r) - 64'(ty2_10_r));
    end
  end

  assign out_vld  = vld_r[10];
  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/cpp_pixel.sv -----
// intrinsics, orientation swap, pixel rounding, margin test and output register
`timescale 1ns / 1ps
`default_nettype none
module cpp_pixel #(
  parameter int LANDSCAPE_WIDTH = 800,
  parameter int EDGE_MARGIN     = 200,
  parameter int LANDSCAPE_HEIGHT = 480
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire cpp_pkg::cpp_dist_out_t in_item,
  input  wire logic [63:0]            intrinsics,
  input  wire logic [23:0]            display,
  output logic                        out_vld,
  output cpp_pkg::cpp_out_t           out_item
);
  import cpp_pkg::*;

  localparam logic signed [17:0] CxBase   = 18'((LANDSCAPE_WIDTH - 1) * 16);
  localparam logic signed [17:0] CyBase   = 18'((LANDSCAPE_HEIGHT - 1) * 16);
  localparam logic signed [51:0] FlipBase = 52'(longint'(LANDSCAPE_WIDTH - 1) << 20);
  localparam logic signed [33:0] MarginNeg = -34'(EDGE_MARGIN);

  logic [3:0] vld_r;
  logic [1:0] st_r [1:3];
  logic signed [48:0] up_1_r, vp_1_r;
  logic signed [51:0] a_2_r, b_2_r;
  logic signed [32:0] px_3_r, py_3_r;
  cpp_out_t out_r;

  logic [15:0] fx, fy, ccx, ccy;
  logic [11:0] width, height;
  logic signed [17:0] cx, cy;
  logic signed [51:0] u, v;
  logic signed [33:0] lim_x, lim_y, pxe, pye;
  logic in_band;

  assign fx     = intrinsics[63:48];
  assign fy     = intrinsics[47:32];
  assign ccx    = intrinsics[31:16];
  assign ccy    = intrinsics[15:0];
  assign width  = display[23:12];
  assign height = display[11:0];

  always_comb begin
    cx      = CxBase - $signed({2'd0, ccx});
    cy      = CyBase - $signed({2'd0, ccy});
    u       = 52'(up_1_r) + (52'(cx) <<< 16);
    v       = 52'(vp_1_r) + (52'(cy) <<< 16);
    lim_x   = $signed(34'(width)) + $signed(34'(EDGE_MARGIN));
    lim_y   = $signed(34'(height)) + $signed(34'(EDGE_MARGIN));
    pxe     = 34'(px_3_r);
    pye     = 34'(py_3_r);
    in_band = (pxe > MarginNeg) && (pxe < lim_x) && (pye > MarginNeg) && (pye < lim_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[1] <= in_item.status;
      st_r[2] <= st_r[1];
      st_r[3] <= st_r[2];
      up_1_r  <= $signed({1'b0, fx}) * in_item.dx;
      vp_1_r  <= $signed({1'b0, fy}) * in_item.dy;
      if (width > height) begin
        a_2_r <= u;
        b_2_r <= v;
      end else begin
        a_2_r <= v;
        b_2_r <= FlipBase - u;
      end
      px_3_r <= 33'(rnd_sym(a_2_r, 20));
      py_3_r <= 33'(rnd_sym(b_2_r, 20));
      if (st_r[3] != ST_VISIBLE) begin
        out_r.status  <= st_r[3];
        out_r.pixel_x <= '0;
        out_r.pixel_y <= '0;
      end else begin
        out_r.status  <= in_band ? ST_VISIBLE : ST_MARGIN;
        out_r.pixel_x <= (px_3_r > 33'sd32767) ? 16'sh7fff :
                         (px_3_r < -33'sd32768) ? 16'sh8000 : px_3_r[15:0];
        out_r.pixel_y <= (py_3_r > 33'sd32767) ? 16'sh7fff :
                         (py_3_r < -33'sd32768) ? 16'sh8000 : py_3_r[15:0];
      end
    end
  end

  assign out_vld  = vld_r[3];
  assign out_item = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/camera_point_projection.sv -----
// top level: configuration registers and the projection pipeline
`timescale 1ns / 1ps
`default_nettype none
// Projects 3-D road points (Q12.12 m) through a loaded view matrix, a pinhole
// divide and Brown-Conrady lens distortion to saturated 16-bit pixels with a
// status code. One point is accepted per clock unless the output stalls. Most
// of the pipeline depth is the 21-stage restoring divider that forms both
// normalized coordinates. The whole pipeline holds while a finished result is
// not taken, and a new point is accepted in any cycle in which the output
// register is empty or being taken. Configuration is to be written only while
// the pipeline is empty (not enforced); register indexes above six are ignored.
module camera_point_projection #(
  parameter int LANDSCAPE_WIDTH  = 800,
  parameter int LANDSCAPE_HEIGHT = 480,
  parameter int EDGE_MARGIN      = 200
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cpp_pkg::cpp_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cpp_pkg::cpp_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_addr,
  input  wire logic [63:0]       cfg_wdata
);
  import cpp_pkg::*;

  logic [47:0] row_zero_r, row_one_r, row_two_r, radial_r;
  logic [63:0] intrinsics_r;
  logic [31:0] tangential_r;
  logic [23:0] display_r;

  logic adv;
  logic rot_vld, div_vld, dist_vld;
  cpp_div_in_t   rot_item;
  cpp_div_out_t  div_item;
  cpp_dist_out_t dist_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_zero_r   <= ROW_ZERO_RST;
      row_one_r    <= ROW_ONE_RST;
      row_two_r    <= ROW_TWO_RST;
      intrinsics_r <= '0;
      radial_r     <= '0;
      tangential_r <= '0;
      display_r    <= DISPLAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ROW_ZERO:   row_zero_r   <= cfg_wdata[47:0];
        CFG_ROW_ONE:    row_one_r    <= cfg_wdata[47:0];
        CFG_ROW_TWO:    row_two_r    <= cfg_wdata[47:0];
        CFG_INTRINSICS: intrinsics_r <= cfg_wdata;
        CFG_RADIAL:     radial_r     <= cfg_wdata[47:0];
        CFG_TANGENTIAL: tangential_r <= cfg_wdata[31:0];
        CFG_DISPLAY:    display_r    <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  cpp_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .in_item  (in_data),
    .row_zero (row_zero_r),
    .row_one  (row_one_r),
    .row_two  (row_two_r),
    .out_vld  (rot_vld),
    .out_item (rot_item)
  );

  cpp_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (rot_vld),
    .in_item  (rot_item),
    .out_vld  (div_vld),
    .out_item (div_item)
  );

  cpp_distort u_distort (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_vld     (div_vld),
    .in_item    (div_item),
    .radial     (radial_r),
    .tangential (tangential_r),
    .out_vld    (dist_vld),
    .out_item   (dist_item)
  );

  cpp_pixel #(
    .LANDSCAPE_WIDTH  (LANDSCAPE_WIDTH),
    .EDGE_MARGIN      (EDGE_MARGIN),
    .LANDSCAPE_HEIGHT (LANDSCAPE_HEIGHT)
  ) u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_vld     (dist_vld),
    .in_item    (dist_item),
    .intrinsics (intrinsics_r),
    .display    (display_r),
    .out_vld    (out_valid),
    .out_item   (out_data)
  );

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_RANGE || out_data.status == ST_BEHIND)
    |-> out_data.pixel_x == 16'sd0 && out_data.pixel_y == 16'sd0)
    else $error("rejected point carries nonzero pixels");

  a_visible_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_VISIBLE
    |-> (32'(out_data.pixel_x) > -32'(EDGE_MARGIN))
     && (32'(out_data.pixel_y) > -32'(EDGE_MARGIN)))
    else $error("visible point lies beyond the margin");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
